[src/mft_pkg.sv]
// Package for the multilevel flow table update block.
// Holds the result codes, the field widths and the default table depths.
// Used by the interfaces, the generic RAM user and the top level.
package mft_pkg;

    localparam int unsigned TagW    = 32;
    localparam int unsigned CountW  = 32;
    localparam int unsigned DigestW = 8;
    localparam int unsigned AuxCntW = 8;
    localparam int unsigned MarkW   = 16;
    localparam int unsigned SlotOneW   = 14;
    localparam int unsigned SlotTwoW   = 13;
    localparam int unsigned SlotThreeW = 11;
    localparam int unsigned SlotAuxW   = 14;

    localparam int unsigned LevelOneDepthDef   = 16384;
    localparam int unsigned LevelTwoDepthDef   = 8192;
    localparam int unsigned LevelThreeDepthDef = 2048;
    localparam int unsigned AuxDepthDef        = 16384;

    localparam logic [7:0]  ThresholdReset = 8'd5;
    localparam logic [31:0] CountMax       = 32'hffff_ffff;

    localparam logic [2:0] AddrThreshold = 3'd0;

    localparam logic [2:0] OcInsert     = 3'd0;
    localparam logic [2:0] OcMerge      = 3'd1;
    localparam logic [2:0] OcAuxNew     = 3'd2;
    localparam logic [2:0] OcAuxUp      = 3'd3;
    localparam logic [2:0] OcPromoteMin = 3'd4;
    localparam logic [2:0] OcPromoteMax = 3'd5;
    localparam logic [2:0] OcAuxReplace = 3'd6;
    localparam logic [2:0] OcAuxDown    = 3'd7;

endpackage

[src/mft_if.sv]
// Valid/ready channel interfaces for the packet items and the result items.
// Depends on mft_pkg for the field widths.
interface mft_in_if;
    logic                                valid;
    logic                                ready;
    logic [mft_pkg::TagW-1:0]            flow_tag;
    logic [mft_pkg::SlotOneW-1:0]        slot_one;
    logic [mft_pkg::SlotTwoW-1:0]        slot_two;
    logic [mft_pkg::SlotThreeW-1:0]      slot_three;
    logic [mft_pkg::SlotAuxW-1:0]        slot_aux;
    logic [mft_pkg::DigestW-1:0]         tag_digest;
    modport source (output valid, flow_tag, slot_one, slot_two, slot_three, slot_aux,
                    tag_digest, input ready);
    modport sink (input valid, flow_tag, slot_one, slot_two, slot_three, slot_aux,
                  tag_digest, output ready);
endinterface

interface mft_out_if;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   outcome;
    logic [1:0]                   level_hit;
    logic [mft_pkg::CountW-1:0]   count_after;
    modport source (output valid, outcome, level_hit, count_after, input ready);
    modport sink (input valid, outcome, level_hit, count_after, output ready);
endinterface

[src/mft_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module mft_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[src/multilevel_flow_table_update.sv]
// Top level of the multilevel flow table update block.
// Depends on mft_pkg, mft_in_if, mft_out_if and mft_ram.
//
//   channel    dir  handshake     payload
//   i_item     in   valid/ready   flow_tag, slot_one..slot_aux, tag_digest
//   o_result   out  valid/ready   outcome, level_hit, count_after
//   apb        in   psel/penable  promote_threshold at byte address 0
//
// An item passes through accept, table read, then decide and write back.
// After reset a clearing pass writes zero to every entry, one address a cycle,
// and no item is accepted meanwhile.
// A result waits in the output register; a stalled output holds the write-back.
// Table depths are powers of two.
module multilevel_flow_table_update #(
    parameter int unsigned LEVEL_ONE_DEPTH   = mft_pkg::LevelOneDepthDef,
    parameter int unsigned LEVEL_TWO_DEPTH   = mft_pkg::LevelTwoDepthDef,
    parameter int unsigned LEVEL_THREE_DEPTH = mft_pkg::LevelThreeDepthDef,
    parameter int unsigned AUX_DEPTH         = mft_pkg::AuxDepthDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mft_in_if.sink      i_item,
    mft_out_if.source   o_result,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    localparam int unsigned A1 = $clog2(LEVEL_ONE_DEPTH);
    localparam int unsigned A2 = $clog2(LEVEL_TWO_DEPTH);
    localparam int unsigned A3 = $clog2(LEVEL_THREE_DEPTH);
    localparam int unsigned AA = $clog2(AUX_DEPTH);
    localparam int unsigned M12 = (LEVEL_ONE_DEPTH > LEVEL_TWO_DEPTH) ?
                                  LEVEL_ONE_DEPTH : LEVEL_TWO_DEPTH;
    localparam int unsigned M3A = (LEVEL_THREE_DEPTH > AUX_DEPTH) ?
                                  LEVEL_THREE_DEPTH : AUX_DEPTH;
    localparam int unsigned MAXD = (M12 > M3A) ? M12 : M3A;
    localparam int unsigned CW = $clog2(MAXD + 1);
    localparam int unsigned MW = mft_pkg::TagW + mft_pkg::CountW;
    localparam int unsigned XW = mft_pkg::MarkW + mft_pkg::DigestW + mft_pkg::AuxCntW;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_READ   = 4'b0100,
        ST_DECIDE = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    logic [CW-1:0] r_clr;
    logic [7:0]  r_thr;
    logic [31:0] r_tag;
    logic [7:0]  r_dig;
    logic [A1-1:0] r_a1;
    logic [A2-1:0] r_a2;
    logic [A3-1:0] r_a3;
    logic [AA-1:0] r_ax;
    logic        r_out_valid;
    logic [2:0]  r_outcome;
    logic [1:0]  r_level;
    logic [31:0] r_count;

    logic [MW-1:0] w_rd1, w_rd2, w_rd3;
    logic [XW-1:0] w_rdx;
    logic          w_go, w_clearing;

    logic [2:0]    w_code;
    logic [1:0]    w_lvl, w_mlvl;
    logic [31:0]   w_cnt;
    logic          w_mzero, w_xwe;
    logic [MW-1:0] w_mword;
    logic [XW-1:0] w_xword;

    logic          we1, we2, we3, wex;
    logic [A1-1:0] wa1;
    logic [A2-1:0] wa2;
    logic [A3-1:0] wa3;
    logic [AA-1:0] wax;
    logic [MW-1:0] wd_main;
    logic [XW-1:0] wd_aux;

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr == mft_pkg::AddrThreshold) ? {24'd0, r_thr} : 32'd0;

    assign i_item.ready = (r_state == ST_IDLE);
    assign w_go = (r_state == ST_DECIDE) && (!r_out_valid || o_result.ready);
    assign w_clearing = (r_state == ST_CLEAR);

    assign o_result.valid       = r_out_valid;
    assign o_result.outcome     = r_outcome;
    assign o_result.level_hit   = r_level;
    assign o_result.count_after = r_count;

    always_comb begin
        logic [31:0] t [3];
        logic [31:0] c [3];
        logic [31:0] min_c, max_c;
        logic [1:0]  min_l, max_l;
        logic        min_z, max_z, done;
        logic [7:0]  xd, xn, up;
        logic [15:0] xm, mark;
        t[0] = w_rd1[63:32]; c[0] = w_rd1[31:0];
        t[1] = w_rd2[63:32]; c[1] = w_rd2[31:0];
        t[2] = w_rd3[63:32]; c[2] = w_rd3[31:0];
        xm = w_rdx[31:16];
        xd = w_rdx[15:8];
        xn = w_rdx[7:0];
        min_c = mft_pkg::CountMax; min_l = 2'd1; min_z = 1'b1;
        max_c = 32'd0;             max_l = 2'd1; max_z = 1'b1;
        done = 1'b0;
        w_code = mft_pkg::OcInsert;
        w_lvl = 2'd0;
        w_mlvl = 2'd0;
        w_cnt = 32'd0;
        w_mzero = 1'b0;
        w_mword = '0;
        w_xwe = 1'b0;
        w_xword = w_rdx;
        for (int k = 0; k < 3; k++) begin
            if (!done) begin
                if (t[k] == 32'd0 && c[k] == 32'd0) begin
                    done = 1'b1;
                    w_code = mft_pkg::OcInsert;
                    w_lvl = 2'(k + 1);
                    w_mlvl = 2'(k + 1);
                    w_cnt = 32'd1;
                    w_mword = {r_tag, 32'd1};
                end else if (t[k] == r_tag) begin
                    done = 1'b1;
                    w_code = mft_pkg::OcMerge;
                    w_lvl = 2'(k + 1);
                    w_mlvl = 2'(k + 1);
                    w_cnt = (c[k] == mft_pkg::CountMax) ? c[k] : c[k] + 32'd1;
                    w_mword = {r_tag, w_cnt};
                end else begin
                    if (c[k] < min_c) begin
                        min_c = c[k]; min_l = 2'(k + 1); min_z = 1'b0;
                    end
                    if (c[k] > max_c) begin
                        max_c = c[k]; max_l = 2'(k + 1); max_z = 1'b0;
                    end
                end
            end
        end
        mark = max_c[15:0];
        up = xn + 8'd1;
        if (!done) begin
            w_xwe = 1'b1;
            if (xd == 8'd0 && xn == 8'd0) begin
                w_code = mft_pkg::OcAuxNew;
                w_cnt = 32'd1;
                w_xword = {mark, r_dig, 8'd1};
            end else if (xd == r_dig) begin
                if ({24'd0, up} > min_c) begin
                    w_code = mft_pkg::OcPromoteMin;
                    w_lvl = min_l;
                    w_mlvl = min_l;
                    w_mzero = min_z;
                    w_cnt = {24'd0, up};
                    w_mword = {r_tag, 24'd0, up};
                    w_xword = {xm, 16'd0};
                end else if (up > r_thr && mark == xm) begin
                    w_code = mft_pkg::OcPromoteMax;
                    w_lvl = max_l;
                    w_mlvl = max_l;
                    w_mzero = max_z;
                    w_cnt = {24'd0, up};
                    w_mword = {r_tag, 24'd0, up};
                    w_xword = {xm, 16'd0};
                end else begin
                    w_code = mft_pkg::OcAuxUp;
                    w_cnt = {24'd0, up};
                    w_xword = {xm, xd, up};
                end
            end else if (xn == 8'd1) begin
                w_code = mft_pkg::OcAuxReplace;
                w_cnt = 32'd1;
                w_xword = {mark, r_dig, 8'd1};
            end else begin
                w_code = mft_pkg::OcAuxDown;
                w_cnt = {24'd0, xn - 8'd1};
                w_xword = {xm, xd, xn - 8'd1};
            end
        end
    end

    always_comb begin
        we1 = w_go && (w_mlvl == 2'd1);
        we2 = w_go && (w_mlvl == 2'd2);
        we3 = w_go && (w_mlvl == 2'd3);
        wex = w_go && w_xwe;
        wa1 = w_mzero ? '0 : r_a1;
        wa2 = r_a2;
        wa3 = r_a3;
        wax = r_ax;
        wd_main = w_mword;
        wd_aux = w_xword;
        if (w_clearing) begin
            we1 = r_clr < CW'(LEVEL_ONE_DEPTH);
            we2 = r_clr < CW'(LEVEL_TWO_DEPTH);
            we3 = r_clr < CW'(LEVEL_THREE_DEPTH);
            wex = r_clr < CW'(AUX_DEPTH);
            wa1 = r_clr[A1-1:0];
            wa2 = r_clr[A2-1:0];
            wa3 = r_clr[A3-1:0];
            wax = r_clr[AA-1:0];
            wd_main = '0;
            wd_aux = '0;
        end
    end

    mft_ram #(.WIDTH(MW), .DEPTH(LEVEL_ONE_DEPTH)) u_lvl1 (
        .i_clk(i_clk), .i_we(we1), .i_waddr(wa1), .i_wdata(wd_main),
        .i_raddr(r_a1), .o_rdata(w_rd1));
    mft_ram #(.WIDTH(MW), .DEPTH(LEVEL_TWO_DEPTH)) u_lvl2 (
        .i_clk(i_clk), .i_we(we2), .i_waddr(wa2), .i_wdata(wd_main),
        .i_raddr(r_a2), .o_rdata(w_rd2));
    mft_ram #(.WIDTH(MW), .DEPTH(LEVEL_THREE_DEPTH)) u_lvl3 (
        .i_clk(i_clk), .i_we(we3), .i_waddr(wa3), .i_wdata(wd_main),
        .i_raddr(r_a3), .o_rdata(w_rd3));
    mft_ram #(.WIDTH(XW), .DEPTH(AUX_DEPTH)) u_aux (
        .i_clk(i_clk), .i_we(wex), .i_waddr(wax), .i_wdata(wd_aux),
        .i_raddr(r_ax), .o_rdata(w_rdx));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == CW'(MAXD - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_item.valid) n_state = ST_READ;
            end
            ST_READ: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (w_go) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr <= '0;
            r_thr <= mft_pkg::ThresholdReset;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_clearing) r_clr <= r_clr + CW'(1);
            if (i_psel && i_penable && i_pwrite && i_paddr == mft_pkg::AddrThreshold) begin
                r_thr <= i_pwdata[7:0];
            end
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_tag <= i_item.flow_tag;
            r_dig <= i_item.tag_digest;
            r_a1 <= A1'(i_item.slot_one);
            r_a2 <= A2'(i_item.slot_two);
            r_a3 <= A3'(i_item.slot_three);
            r_ax <= AA'(i_item.slot_aux);
        end
        if (w_go) begin
            r_outcome <= w_code;
            r_level <= w_lvl;
            r_count <= w_cnt;
        end
    end

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !i_item.ready)
        else $error("item accepted during clearing pass");
    a_result_after_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !$past(o_result.valid)) |-> $past(r_state == ST_DECIDE))
        else $error("result appeared without a decide cycle");
    a_aux_level_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.outcome == mft_pkg::OcAuxNew ||
         o_result.outcome == mft_pkg::OcAuxUp || o_result.outcome == mft_pkg::OcAuxReplace ||
         o_result.outcome == mft_pkg::OcAuxDown)) |-> (o_result.level_hit == 2'd0))
        else $error("ancillary outcome reports a main level");
    a_main_level_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.outcome == mft_pkg::OcInsert ||
         o_result.outcome == mft_pkg::OcMerge)) |-> (o_result.level_hit != 2'd0))
        else $error("main table outcome without a level");
endmodule
